/* rtl/tspi_pkg.sv */
package tspi_pkg;

   localparam int STAMP_W = 63;
   localparam int POS_W   = 32;
   localparam int STAT_W  = 2;

   typedef enum logic [STAT_W-1:0] {
      STAT_EMPTY  = 2'd0,
      STAT_OLDEST = 2'd1,
      STAT_NEWEST = 2'd2,
      STAT_INTERP = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_RD,
      ST_CMP,
      ST_PREV,
      ST_DIV,
      ST_MUL,
      ST_SUM,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic write;
      logic scan_start;
      logic scan_next;
      logic read_prev;
      logic div_start;
      logic div_step;
      logic mul_sel;
      logic mul_go;
      logic sum_go;
      logic set_clamp;
      logic set_empty;
      logic rsp_set;
      logic rsp_clr;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic empty;
      logic later;
      logic last;
      logic first;
      logic div_done;
      logic mul_last;
      logic rsp_busy;
   } stat_type;

endpackage

/* rtl/tspi_ctrl.sv */
module tspi_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tspi_pkg::stat_type stat,
   output tspi_pkg::cmd_type  cmd
);

   tspi_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tspi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         tspi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = tspi_pkg::ST_WRITE;
            end
         end
         tspi_pkg::ST_WRITE: begin
            if (!stat.is_query) begin
               cmd.write = 1'b1;
               state_in  = tspi_pkg::ST_IDLE;
            end else if (!stat.rsp_busy) begin
               if (stat.empty) begin
                  cmd.set_empty = 1'b1;
                  state_in      = tspi_pkg::ST_OUT;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = tspi_pkg::ST_RD;
               end
            end
         end
         tspi_pkg::ST_RD: state_in = tspi_pkg::ST_CMP;
         tspi_pkg::ST_CMP: begin
            if (stat.later && !stat.last) begin
               cmd.scan_next = 1'b1;
               state_in      = tspi_pkg::ST_RD;
            end else if (stat.later || stat.first) begin
               cmd.set_clamp = 1'b1;
               state_in      = tspi_pkg::ST_OUT;
            end else begin
               cmd.read_prev = 1'b1;
               state_in      = tspi_pkg::ST_PREV;
            end
         end
         tspi_pkg::ST_PREV: begin
            cmd.div_start = 1'b1;
            state_in      = tspi_pkg::ST_DIV;
         end
         tspi_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = tspi_pkg::ST_MUL;
            end
         end
         tspi_pkg::ST_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = tspi_pkg::ST_SUM;
         end
         tspi_pkg::ST_SUM: begin
            cmd.sum_go = 1'b1;
            if (stat.mul_last) begin
               state_in = tspi_pkg::ST_OUT;
            end else begin
               cmd.mul_sel = 1'b1;
               state_in    = tspi_pkg::ST_MUL;
            end
         end
         tspi_pkg::ST_OUT: begin
            cmd.rsp_set = 1'b1;
            state_in    = tspi_pkg::ST_IDLE;
         end
         default: state_in = tspi_pkg::ST_IDLE;
      endcase
   end

endmodule

/* rtl/tspi_dp.sv */
module tspi_dp #(
   parameter int HISTORY_DEPTH   = 64,
   parameter int RATIO_FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_type,
   input  logic [tspi_pkg::STAMP_W-1:0]   stamp_ns,
   input  logic signed [tspi_pkg::POS_W-1:0] pos_x,
   input  logic signed [tspi_pkg::POS_W-1:0] pos_y,
   input  logic signed [tspi_pkg::POS_W-1:0] pos_z,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [tspi_pkg::POS_W-1:0] out_x,
   output logic signed [tspi_pkg::POS_W-1:0] out_y,
   output logic signed [tspi_pkg::POS_W-1:0] out_z,
   output logic [tspi_pkg::STAT_W-1:0]    status,
   input  tspi_pkg::cmd_type              cmd,
   output tspi_pkg::stat_type             stat
);

   localparam int AW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW  = $clog2(HISTORY_DEPTH + 1);
   localparam int SW  = tspi_pkg::STAMP_W;
   localparam int PW  = tspi_pkg::POS_W;
   localparam int F   = RATIO_FRAC_BITS;
   localparam int FCW = $clog2(F + 1);
   localparam int EW  = 3 * PW;
   localparam int MW  = PW + F + 2;
   localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

   logic [SW-1:0] t_mem [HISTORY_DEPTH];
   logic [EW-1:0] p_mem [HISTORY_DEPTH];

   logic                 type_ff;
   logic [SW-1:0]        q_ff;
   logic [EW-1:0]        pin_ff;
   logic [AW-1:0]        old_ff;
   logic [CW-1:0]        cnt_ff;
   logic [CW-1:0]        k_ff;
   logic [AW-1:0]        raddr;
   logic [SW-1:0]        t_rd_ff;
   logic [EW-1:0]        p_rd_ff;
   logic [SW-1:0]        t_cur_ff;
   logic [EW-1:0]        p_cur_ff;
   logic                 later;
   logic [SW:0]          rem_ff;
   logic [SW-1:0]        den_ff;
   logic [F-1:0]         r_ff;
   logic [FCW-1:0]       dcnt_ff;
   logic [1:0]           ax_ff;
   logic signed [MW-1:0] m1_ff, m2_ff;
   logic [EW-1:0]        acc_ff;
   logic                 vld_ff;
   tspi_pkg::status_type st_ff;
   logic [EW-1:0]        res_ff;
   logic [AW-1:0]        wslot;
   logic [CW:0]          wsum;
   logic [CW:0]          rsum;
   logic [SW:0]          rem_sh;
   logic signed [PW-1:0] a_cur, a_prv;
   logic signed [F+1:0]  r_s, rc_s;
   logic signed [MW:0]   sum_w;
   logic [PW-1:0]        axis_res;

   assign wsum  = {1'b0, cnt_ff} + (CW+1)'(old_ff);
   assign wslot = AW'(wsum >= (CW+1)'(HISTORY_DEPTH) ?
                      wsum - (CW+1)'(HISTORY_DEPTH) : wsum);

   always_comb begin
      logic [CW-1:0] kk;
      kk = cmd.scan_start ? '0 : (cmd.read_prev ? k_ff - 1'b1 : k_ff + 1'b1);
      rsum  = {1'b0, kk} + (CW+1)'(old_ff);
      raddr = AW'(rsum >= (CW+1)'(HISTORY_DEPTH) ?
                  rsum - (CW+1)'(HISTORY_DEPTH) : rsum);
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         t_mem[wslot] <= q_ff;
         p_mem[wslot] <= pin_ff;
      end
      if (cmd.scan_start || cmd.scan_next || cmd.read_prev) begin
         t_rd_ff <= t_mem[raddr];
         p_rd_ff <= p_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         old_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.write) begin
         if (cnt_ff != DEPTH_C) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (old_ff == AW'(HISTORY_DEPTH - 1)) begin
            old_ff <= '0;
         end else begin
            old_ff <= old_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_type;
         q_ff    <= stamp_ns;
         pin_ff  <= {pos_x, pos_y, pos_z};
      end
      if (cmd.scan_start) begin
         k_ff <= '0;
      end else if (cmd.scan_next) begin
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.set_clamp || cmd.read_prev) begin
         t_cur_ff <= t_rd_ff;
         p_cur_ff <= p_rd_ff;
      end
   end

   assign later = q_ff > t_rd_ff;

   assign rem_sh = {rem_ff[SW-1:0], 1'b0};
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff  <= {1'b0, t_cur_ff - q_ff};
         den_ff  <= t_cur_ff - t_rd_ff;
         r_ff    <= '0;
         dcnt_ff <= '0;
         ax_ff   <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + 1'b1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff <= rem_sh - {1'b0, den_ff};
            r_ff   <= {r_ff[F-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            r_ff   <= {r_ff[F-2:0], 1'b0};
         end
      end else if (cmd.mul_sel) begin
         ax_ff <= ax_ff + 1'b1;
      end
   end

   always_comb begin
      case (ax_ff)
         2'd0:    begin a_cur = p_cur_ff[EW-1 -: PW]; a_prv = p_rd_ff[EW-1 -: PW]; end
         2'd1:    begin a_cur = p_cur_ff[2*PW-1 -: PW]; a_prv = p_rd_ff[2*PW-1 -: PW]; end
         default: begin a_cur = p_cur_ff[PW-1:0]; a_prv = p_rd_ff[PW-1:0]; end
      endcase
      r_s  = $signed({2'b00, r_ff});
      rc_s = $signed((F+2)'(1) <<< F) - r_s;
   end

   assign sum_w    = {m1_ff[MW-1], m1_ff} + {m2_ff[MW-1], m2_ff};
   assign axis_res = sum_w[F +: PW];

   always_ff @(posedge clock) begin
      if (cmd.mul_go) begin
         m1_ff <= MW'(a_cur * rc_s);
         m2_ff <= MW'(a_prv * r_s);
      end
      if (cmd.sum_go) begin
         acc_ff <= {acc_ff[2*PW-1:0], axis_res};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (cmd.rsp_set) begin
         vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_empty) begin
         st_ff  <= tspi_pkg::STAT_EMPTY;
         res_ff <= '0;
      end else if (cmd.set_clamp) begin
         st_ff  <= later ? tspi_pkg::STAT_NEWEST : tspi_pkg::STAT_OLDEST;
         res_ff <= p_rd_ff;
      end else if (cmd.rsp_set && st_ff == tspi_pkg::STAT_INTERP) begin
         res_ff <= acc_ff;
      end else if (cmd.div_start) begin
         st_ff <= tspi_pkg::STAT_INTERP;
      end
   end

   assign rsp_valid = vld_ff;
   assign out_x     = res_ff[EW-1 -: PW];
   assign out_y     = res_ff[2*PW-1 -: PW];
   assign out_z     = res_ff[PW-1:0];
   assign status    = st_ff;

   assign stat.is_query = type_ff;
   assign stat.empty    = cnt_ff == '0;
   assign stat.later    = later;
   assign stat.last     = (k_ff + 1'b1) == cnt_ff;
   assign stat.first    = k_ff == '0;
   assign stat.div_done = dcnt_ff == FCW'(F - 1);
   assign stat.mul_last = ax_ff == 2'd2;
   assign stat.rsp_busy = vld_ff && !rsp_ready;

endmodule

/* rtl/timestamped_pose_interpolator.sv */
// timestamped pose interpolator
// req channel: req_type 0 records a pose (stamp_ns, pos_x/y/z) into a ring of
// HISTORY_DEPTH entries, oldest overwritten when full; no rsp word follows.
// req_type 1 queries the pose at stamp_ns and gives one rsp word: out_x/y/z
// and status (0 empty, 1 oldest, 2 newest, 3 interpolated).
// one item is taken at a time; req_ready is high only while idle.
// query: the history is scanned entry by entry (one memory read and one compare
// each), then the restoring ratio divider gives RATIO_FRAC_BITS fraction bits
// and the three axis multiplies follow.
// the rsp word sits in an output register; a new item is accepted while it
// waits, but a query does not start its scan until the word is taken.
// reset empties the history and drops any pending rsp word; the stores are
// not cleared.
module timestamped_pose_interpolator #(
   parameter int HISTORY_DEPTH   = 64,
   parameter int RATIO_FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_type,
   input  logic [tspi_pkg::STAMP_W-1:0]       req_stamp_ns,
   input  logic signed [tspi_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [tspi_pkg::POS_W-1:0]  req_pos_y,
   input  logic signed [tspi_pkg::POS_W-1:0]  req_pos_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [tspi_pkg::POS_W-1:0]  rsp_out_x,
   output logic signed [tspi_pkg::POS_W-1:0]  rsp_out_y,
   output logic signed [tspi_pkg::POS_W-1:0]  rsp_out_z,
   output logic [tspi_pkg::STAT_W-1:0]        rsp_status
);

   tspi_pkg::cmd_type  cmd;
   tspi_pkg::stat_type stat;

   tspi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tspi_dp #(
      .HISTORY_DEPTH   (HISTORY_DEPTH),
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_type  (req_type),
      .stamp_ns  (req_stamp_ns),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .pos_z     (req_pos_z),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .out_x     (rsp_out_x),
      .out_y     (rsp_out_y),
      .out_z     (rsp_out_z),
      .status    (rsp_status),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

/* rtl/tspi_checker.sv */
module tspi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_out_x,
   input logic [31:0] rsp_out_y,
   input logic [31:0] rsp_out_z
);

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_out_x);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("rsp word changed while stalled");

   property p_empty_zero;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_status == tspi_pkg::STAT_EMPTY |->
            rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0;
   endproperty
   a_empty_zero: assert property (p_empty_zero) else $error("empty status with nonzero pose");

   property p_no_rsp_after_reset;
      @(posedge clock) $past(reset) |-> !rsp_valid;
   endproperty
   a_no_rsp_after_reset: assert property (p_no_rsp_after_reset)
      else $error("rsp word right after reset");

   property p_busy_after_accept;
      @(posedge clock) disable iff (reset) req_valid && req_ready |=> !req_ready;
   endproperty
   a_busy_after_accept: assert property (p_busy_after_accept)
      else $error("req accepted back to back");

endmodule

bind timestamped_pose_interpolator tspi_checker u_tspi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_status (rsp_status),
   .rsp_out_x  (rsp_out_x),
   .rsp_out_y  (rsp_out_y),
   .rsp_out_z  (rsp_out_z)
);
